### src/ctpt_pkg.sv
// ----------------------------------------------------------------------------
// ctpt_pkg: shared definitions for the camera trigger pulse train
// Opcodes, clamp limits, stream widths and the controller/datapath link.
// ----------------------------------------------------------------------------
package ctpt_pkg;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_SINGLE = 3'd1;
	localparam logic [2:0] OP_START  = 3'd2;
	localparam logic [2:0] OP_STOP   = 3'd3;
	localparam logic [2:0] OP_FRAME  = 3'd4;

	localparam logic [19:0] WIDTH_MIN     = 20'd10;
	localparam logic [19:0] WIDTH_MAX     = 20'd1000000;
	localparam logic [19:0] WIDTH_RESET   = 20'd1000;
	localparam logic [31:0] PERIOD_MARGIN = 32'd100;
	localparam logic [31:0] PERIOD_MAX    = 32'd1800000000;

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 72;

	// The catch-up dividend is below 2^31, so 31 restoring steps suffice.
	localparam int DIV_STEPS = 31;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic accept;
		logic div_start;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

### src/ctpt_rem.sv
// ----------------------------------------------------------------------------
// ctpt_rem: serial remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module ctpt_rem
	import ctpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] dividend,
	input  logic [30:0] divisor,
	output logic        busy,
	output logic [30:0] remainder
);

	logic [30:0]          quo_q;
	logic [30:0]          rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [31:0]          trial;
	logic [31:0]          rem_next;

	// The partial remainder stays below the divisor, so it fits in 31 bits.
	always_comb begin
		trial = {rem_q, quo_q[30]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = trial - {1'b0, divisor};
		end else begin
			rem_next = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[29:0], 1'b0};
			rem_q <= rem_next[30:0];
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

### src/ctpt_dp.sv
// ----------------------------------------------------------------------------
// ctpt_dp: trigger datapath
// Holds the item, the trigger and train state, the width register and the
// output register, and computes the next state of one item.
// ----------------------------------------------------------------------------
module ctpt_dp
	import ctpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [2:0]           s_tuser,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	output logic [19:0]          width
);

	logic [2:0]  op_q;
	logic [31:0] now_q;
	logic [31:0] per_q;

	logic [19:0] width_q;
	logic        pulse_active_q;
	logic [31:0] pulse_start_q;
	logic        train_active_q;
	logic [30:0] train_period_q;
	logic [31:0] next_deadline_q;
	logic [31:0] frame_count_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [19:0] wr_width;
	logic [31:0] since_start;
	logic [31:0] since_deadline;
	logic        pulse_held;
	logic        train_fire;
	logic [30:0] divisor;
	logic        div_busy;
	logic [30:0] remainder;
	logic [31:0] period_lo;
	logic [31:0] period_clamped;

	logic        pa_n;
	logic [31:0] ps_n;
	logic        ta_n;
	logic [30:0] tp_n;
	logic [31:0] nd_n;
	logic [31:0] fc_n;
	logic        started;
	logic        frame;

	always_comb begin
		if (cfg_wdata[19:0] < WIDTH_MIN) begin
			wr_width = WIDTH_MIN;
		end else if (cfg_wdata[19:0] > WIDTH_MAX) begin
			wr_width = WIDTH_MAX;
		end else begin
			wr_width = cfg_wdata[19:0];
		end
	end

	assign since_start    = now_q - pulse_start_q;
	assign since_deadline = now_q - next_deadline_q;
	assign pulse_held     = pulse_active_q && (since_start < {12'b0, width_q});
	assign train_fire     = train_active_q && !pulse_held && !since_deadline[31];
	assign divisor        = (train_period_q == '0) ? 31'd1 : train_period_q;

	ctpt_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (since_deadline[30:0]),
		.divisor   (divisor),
		.busy      (div_busy),
		.remainder (remainder)
	);

	assign period_lo = {12'b0, width_q} + PERIOD_MARGIN;

	always_comb begin
		if (per_q < period_lo) begin
			period_clamped = period_lo;
		end else if (per_q > PERIOD_MAX) begin
			period_clamped = PERIOD_MAX;
		end else begin
			period_clamped = per_q;
		end
	end

	always_comb begin
		pa_n    = pulse_active_q;
		ps_n    = pulse_start_q;
		ta_n    = train_active_q;
		tp_n    = train_period_q;
		nd_n    = next_deadline_q;
		fc_n    = frame_count_q;
		started = 1'b0;
		frame   = 1'b0;
		unique case (op_q)
			OP_TICK: begin
				pa_n = pulse_held;
				if (train_fire) begin
					pa_n    = 1'b1;
					ps_n    = now_q;
					started = 1'b1;
					// Skipping all missed periods lands at now - (d mod p) + p.
					nd_n    = now_q - {1'b0, remainder} + {1'b0, divisor};
				end
			end
			OP_SINGLE: begin
				pa_n    = 1'b1;
				ps_n    = now_q;
				started = 1'b1;
			end
			OP_START: begin
				tp_n = period_clamped[30:0];
				nd_n = now_q;
				ta_n = 1'b1;
			end
			OP_STOP: begin
				ta_n = 1'b0;
			end
			OP_FRAME: begin
				fc_n  = frame_count_q + 32'd1;
				frame = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= s_tuser;
			now_q <= s_tdata[31:0];
			per_q <= s_tdata[63:32];
		end
		if (cmd.commit) begin
			m_tdata_q <= {5'b0, ((started || frame) ? now_q : 32'd0), fc_n,
				frame, started, pa_n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q         <= WIDTH_RESET;
			pulse_active_q  <= 1'b0;
			pulse_start_q   <= '0;
			train_active_q  <= 1'b0;
			train_period_q  <= '0;
			next_deadline_q <= '0;
			frame_count_q   <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				width_q <= wr_width;
			end
			if (cmd.commit) begin
				pulse_active_q  <= pa_n;
				pulse_start_q   <= ps_n;
				train_active_q  <= ta_n;
				train_period_q  <= tp_n;
				next_deadline_q <= nd_n;
				frame_count_q   <= fc_n;
				m_tvalid_q      <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign status.need_div = (op_q == OP_TICK) && train_fire;
	assign status.div_busy = div_busy;
	assign status.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign width    = width_q;

endmodule

### src/ctpt_ctrl.sv
// ----------------------------------------------------------------------------
// ctpt_ctrl: trigger controller
// Sequences accept, evaluation, the catch-up division and the commit.
// ----------------------------------------------------------------------------
module ctpt_ctrl
	import ctpt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EVAL   = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;

	always_comb begin
		state_n       = state_q;
		cmd.accept    = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_n    = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.need_div) begin
					cmd.div_start = 1'b1;
					state_n       = ST_DIV;
				end else begin
					state_n = ST_COMMIT;
				end
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					state_n = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

### src/camera_trigger_pulse_train.sv
// ----------------------------------------------------------------------------
// camera_trigger_pulse_train: timestamped camera trigger generator
// Flow: each transaction passes through accept, evaluation and a commit that
//   loads the output register; a tick that fires a train pulse also runs the
//   31-step serial remainder, and the commit waits for a free output register.
//   One item is in work at a time.
// Reset: arst_n clears the control, trigger, train and frame state and the
//   output valid flag; the pulse width returns to 1000 us.
// ----------------------------------------------------------------------------
module camera_trigger_pulse_train
	import ctpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream. tuser: opcode[2:0]. tdata: now_us[31:0], period_us[63:32].
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2:0]           s_tuser,
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Result stream. tdata: trigger_level[0], trigger_started[1],
	// frame_seen[2], frame_number[34:3], event_time_us[66:35], zeros above.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	// Configuration port; the pulse width register lies at byte address 0.
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// The controller moves each transaction through accept, evaluation, an
	// optional catch-up division and a commit that loads the output register.
	// The output register lets a new transaction be accepted while a result
	// still waits downstream.

	cmd_t        cmd;
	status_t     status;
	logic        cfg_we;
	logic [19:0] width;

	// Only word address zero holds a register; writes elsewhere are dropped.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {12'b0, width} : 32'd0;

	ctpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ctpt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata),
		.width     (width)
	);

	// After an accepted transaction the block is busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted on two consecutive cycles");

	// A pulse that began on this item leaves the trigger high.
	a_started_level: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> m_tdata[0])
		else $error("trigger started but level low");

	// A pulse start and a frame edge never come from one transaction.
	a_event_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
		else $error("trigger start and frame edge in one result");

	// Without an event the reported time is zero.
	a_event_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1] && !m_tdata[2]) |-> (m_tdata[66:35] == 32'd0))
		else $error("event time reported without an event");

endmodule
